/* rtl/core/triangle_bilinear_image_resizer_macros.svh */
// assertion macros for the triangle bilinear image resizer
// included by the top level, no other dependencies
`ifndef TRIANGLE_BILINEAR_IMAGE_RESIZER_MACROS_SVH
`define TRIANGLE_BILINEAR_IMAGE_RESIZER_MACROS_SVH
`ifndef SYNTHESIS
`define TBIR_ASSERT(label, clk_i, rst_ni, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("assertion failed");
`define TBIR_ASSERT_NEVER(label, clk_i, rst_ni, prop) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
		else $error("assertion failed");
`else
`define TBIR_ASSERT(label, clk_i, rst_ni, prop)
`define TBIR_ASSERT_NEVER(label, clk_i, rst_ni, prop)
`endif
`endif

/* rtl/core/tbir_pkg.sv */
// shared types and constants of the triangle bilinear image resizer
// no dependencies
package tbir_pkg;
	localparam int CH_W = 8;
	localparam int POS_W = 24;
	localparam int PIX_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DST_W = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DST_H = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_INC = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_INC = 3'd5;
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EMIT = 1'b1;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_WAIT,
		BK_BLEND
	} back_state_t;
endpackage

/* rtl/core/tbir_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module tbir_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

/* rtl/core/tbir_front.sv */
// front end: accepts beats, tracks destination raster and source position
// depends on tbir_pkg
module tbir_front import tbir_pkg::*; #(
	parameter int SRC_DIM = 256,
	parameter int DST_DIM = 1024,
	parameter int FRAC = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_action,
	input  logic [PIX_W-1:0]              in_pix,
	input  logic [$clog2(DST_DIM+1)-1:0]  dw,
	input  logic [$clog2(DST_DIM+1)-1:0]  dh,
	input  logic [POS_W-1:0]              x_inc,
	input  logic [POS_W-1:0]              y_inc,
	input  logic                          back_busy,
	// store write
	output logic                          wr_en,
	output logic [$clog2(SRC_DIM*SRC_DIM)-1:0] wr_addr,
	output logic [PIX_W-1:0]              wr_data,
	// queue of emit jobs
	output logic                          q_valid,
	input  logic                          q_ready,
	output logic [2*POS_W:0]              q_data
);
	localparam int AW = $clog2(SRC_DIM*SRC_DIM);
	localparam int DCW = $clog2(DST_DIM+1);
	localparam int QD = 2;

	logic [AW-1:0]      load_ptr_q;
	logic [POS_W-1:0]   xpos_q, ypos_q;
	logic [DCW-1:0]     col_q, row_q;
	logic [2*POS_W:0]   fifo_q [QD];
	logic               wp_q, rp_q;
	logic [1:0]         cnt_q;
	logic               acc, push, pop, col_end, last;

	// a load waits until no queued or running emit still has store reads ahead
	assign in_ready = (cnt_q != 2'(QD)) &&
		((in_action == ACT_EMIT) || ((cnt_q == 2'd0) && !back_busy));
	assign acc = in_valid && in_ready;
	assign push = acc && (in_action == ACT_EMIT);
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = fifo_q[rp_q];
	assign col_end = ({1'b0, col_q} + 1'b1) >= {1'b0, dw};
	assign last = col_end && (({1'b0, row_q} + 1'b1) >= {1'b0, dh});
	assign wr_en = acc && (in_action == ACT_LOAD);
	assign wr_addr = load_ptr_q;
	assign wr_data = in_pix;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= {last, ypos_q, xpos_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			xpos_q <= '0;
			ypos_q <= '0;
			col_q <= '0;
			row_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (wr_en) load_ptr_q <= load_ptr_q + 1'b1;
			if (push) begin
				if (last) begin
					xpos_q <= '0;
					ypos_q <= '0;
					col_q <= '0;
					row_q <= '0;
					load_ptr_q <= '0;
				end else if (col_end) begin
					col_q <= '0;
					xpos_q <= '0;
					row_q <= row_q + 1'b1;
					ypos_q <= ypos_q + y_inc;
				end else begin
					col_q <= col_q + 1'b1;
					xpos_q <= xpos_q + x_inc;
				end
			end
		end
	end
endmodule

/* rtl/core/tbir_back.sv */
// back end: fetches three neighbors one at a time and blends them
// depends on tbir_pkg and tbir_ram
module tbir_back import tbir_pkg::*; #(
	parameter int SRC_DIM = 256,
	parameter int FRAC = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_ready,
	input  logic [2*POS_W:0]              q_data,
	input  logic [$clog2(SRC_DIM+1)-1:0]  sw,
	input  logic [$clog2(SRC_DIM+1)-1:0]  sh,
	input  logic                          wr_en,
	input  logic [$clog2(SRC_DIM*SRC_DIM)-1:0] wr_addr,
	input  logic [PIX_W-1:0]              wr_data,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [PIX_W-1:0]              out_pix,
	output logic                          out_last
);
	localparam int AW = $clog2(SRC_DIM*SRC_DIM);
	localparam int SDW = $clog2(SRC_DIM+1);
	localparam int IW = POS_W - FRAC + 1;
	localparam int PW = 2*CH_W + FRAC + 4;

	back_state_t state_q, state_d;
	logic [1:0]       idx_q;
	logic [IW-1:0]    xi_q, yi_q;
	logic [FRAC:0]    xf_q, yf_q;
	logic             last_q, flip_q;
	logic [PIX_W-1:0] pa_q, pb_q;
	logic [PIX_W-1:0] rd_data;
	logic [AW-1:0]    rd_addr;
	logic [IW-1:0]    cx, cy, ccx, ccy;
	logic [FRAC:0]    fx, fy;
	logic [PIX_W-1:0] res;
	logic             take;

	tbir_ram #(.WIDTH(PIX_W), .DEPTH(SRC_DIM*SRC_DIM)) u_ram (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	assign fx = {1'b0, q_data[FRAC-1:0]};
	assign fy = {1'b0, q_data[POS_W+FRAC-1:POS_W]};
	assign q_ready = (state_q == BK_IDLE) && !out_valid;
	assign take = q_valid && q_ready;
	assign busy = (state_q != BK_IDLE);

	// neighbor for this read: a, b, c order per triangle
	always_comb begin
		cx = xi_q;
		cy = yi_q;
		unique case (idx_q)
			2'd0: begin
				cx = xi_q + IW'(flip_q);
				cy = yi_q + IW'(flip_q);
			end
			2'd1: begin
				cx = xi_q + IW'(!flip_q ? 1'b1 : 1'b0);
				cy = yi_q + IW'(flip_q);
			end
			default: begin
				cx = xi_q + IW'(flip_q);
				cy = yi_q + IW'(!flip_q ? 1'b1 : 1'b0);
			end
		endcase
		if (flip_q && idx_q == 2'd1) cx = xi_q;
		if (flip_q && idx_q == 2'd2) cy = yi_q;
		ccx = (cx >= IW'(sw)) ? IW'(sw) - 1'b1 : cx;
		ccy = (cy >= IW'(sh)) ? IW'(sh) - 1'b1 : cy;
		rd_addr = AW'(ccy) * AW'(sw) + AW'(ccx);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (take) state_d = BK_READ;
			BK_READ:  state_d = BK_WAIT;
			BK_WAIT:  state_d = (idx_q == 2'd2) ? BK_BLEND : BK_READ;
			BK_BLEND: state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic signed [PW-1:0] s;
			logic signed [PW-1:0] q;
			s = (PW'(signed'({1'b0, pb_q[c*CH_W +: CH_W]})) -
			     PW'(signed'({1'b0, pa_q[c*CH_W +: CH_W]}))) *
			    PW'(signed'({1'b0, xf_q})) +
			    (PW'(signed'({1'b0, rd_data[c*CH_W +: CH_W]})) -
			     PW'(signed'({1'b0, pa_q[c*CH_W +: CH_W]}))) *
			    PW'(signed'({1'b0, yf_q}));
			q = s >>> FRAC;
			res[c*CH_W +: CH_W] = pa_q[c*CH_W +: CH_W] + q[CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			xi_q <= IW'(q_data[POS_W-1:FRAC]);
			yi_q <= IW'(q_data[2*POS_W-1:POS_W+FRAC]);
			last_q <= q_data[2*POS_W];
			flip_q <= (fx + fy) > (FRAC+1)'(1 << FRAC);
			if ((fx + fy) > (FRAC+1)'(1 << FRAC)) begin
				xf_q <= (FRAC+1)'(1 << FRAC) - fx;
				yf_q <= (FRAC+1)'(1 << FRAC) - fy;
			end else begin
				xf_q <= fx;
				yf_q <= fy;
			end
		end
		if (state_q == BK_WAIT && idx_q == 2'd0) pa_q <= rd_data;
		if (state_q == BK_WAIT && idx_q == 2'd1) pb_q <= rd_data;
		if (state_q == BK_WAIT && idx_q == 2'd2) begin
			out_pix <= res;
			out_last <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) idx_q <= '0;
			else if (state_q == BK_WAIT && idx_q != 2'd2) idx_q <= idx_q + 1'b1;
			if (state_q == BK_WAIT && idx_q == 2'd2) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	logic unused_sdw;
	assign unused_sdw = ^{SDW'(0)};
endmodule

/* rtl/core/triangle_bilinear_image_resizer.sv */
// triangle bilinear image resizer: load beats fill a source store, emit beats yield
// one interpolated pixel each through a two-entry queue; depends on tbir_pkg,
// tbir_front, tbir_back, tbir_ram and the macros header
// the back end takes one emit job at a time, after the three serial store reads
// and result hand-off of the previous one; loads 1/cycle, held while emit reads are
// pending; arst_n resets control and config state, not datapath or source store
`include "triangle_bilinear_image_resizer_macros.svh"
module triangle_bilinear_image_resizer import tbir_pkg::*; #(
	parameter int MAX_SOURCE_DIM = 256,
	parameter int MAX_DEST_DIM = 1024,
	parameter int FRACTION_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                  s_axis_tuser,  // action
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // out_red, out_green, out_blue
	output logic                  m_axis_tlast,  // last_pixel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int SDW = $clog2(MAX_SOURCE_DIM+1);
	localparam int DCW = $clog2(MAX_DEST_DIM+1);
	localparam int AW = $clog2(MAX_SOURCE_DIM*MAX_SOURCE_DIM);

	// raw register values
	logic [8:0]       src_w_q, src_h_q;
	logic [10:0]      dst_w_q, dst_h_q;
	logic [POS_W-1:0] x_inc_q, y_inc_q;
	logic [SDW-1:0]   sw, sh;
	logic [DCW-1:0]   dw, dh;
	logic             wr_en, q_valid, q_ready, back_busy;
	logic [AW-1:0]    wr_addr;
	logic [PIX_W-1:0] wr_data, in_pix, out_pix;
	logic [2*POS_W:0] q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= 9'd256;
			src_h_q <= 9'd256;
			dst_w_q <= 11'd256;
			dst_h_q <= 11'd256;
			x_inc_q <= 24'd65536;
			y_inc_q <= 24'd65536;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SRC_W: src_w_q <= cfg_data[8:0];
				REG_SRC_H: src_h_q <= cfg_data[8:0];
				REG_DST_W: dst_w_q <= cfg_data[10:0];
				REG_DST_H: dst_h_q <= cfg_data[10:0];
				REG_X_INC: x_inc_q <= cfg_data;
				REG_Y_INC: y_inc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sizes of zero act as one, oversize saturates
	always_comb begin
		sw = (src_w_q == 0) ? SDW'(1) :
		     (32'(src_w_q) > MAX_SOURCE_DIM) ? SDW'(MAX_SOURCE_DIM) : SDW'(src_w_q);
		sh = (src_h_q == 0) ? SDW'(1) :
		     (32'(src_h_q) > MAX_SOURCE_DIM) ? SDW'(MAX_SOURCE_DIM) : SDW'(src_h_q);
		dw = (dst_w_q == 0) ? DCW'(1) :
		     (32'(dst_w_q) > MAX_DEST_DIM) ? DCW'(MAX_DEST_DIM) : DCW'(dst_w_q);
		dh = (dst_h_q == 0) ? DCW'(1) :
		     (32'(dst_h_q) > MAX_DEST_DIM) ? DCW'(MAX_DEST_DIM) : DCW'(dst_h_q);
	end

	// store packs red high, blue low
	assign in_pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
	assign m_axis_tdata = {out_pix[7:0], out_pix[15:8], out_pix[23:16]};

	tbir_front #(.SRC_DIM(MAX_SOURCE_DIM), .DST_DIM(MAX_DEST_DIM),
		.FRAC(FRACTION_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_action(s_axis_tuser), .in_pix(in_pix),
		.dw(dw), .dh(dh), .x_inc(x_inc_q), .y_inc(y_inc_q),
		.back_busy(back_busy),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	tbir_back #(.SRC_DIM(MAX_SOURCE_DIM), .FRAC(FRACTION_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.sw(sw), .sh(sh),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
		.busy(back_busy),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_pix(out_pix), .out_last(m_axis_tlast)
	);

	// a stalled result holds its payload
	`TBIR_ASSERT(a_out_hold, clk, arst_n,
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
	// the back end never takes a queue entry while a result is pending
	`TBIR_ASSERT_NEVER(a_q_flow, clk, arst_n, q_ready && m_axis_tvalid)
endmodule

/* sim/tb.sv */
// regression bench for the triangle bilinear image resizer
// depends on tbir_pkg and the triangle_bilinear_image_resizer top level
module tb import tbir_pkg::*;;
	localparam int STORE_DEPTH = 65536;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} dest_pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // in_red, in_green, in_blue
	logic s_axis_tuser = ACT_LOAD;  // action
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // out_red, out_green, out_blue
	logic m_axis_tlast;  // last_pixel
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the block's registers and state
	logic [8:0] src_w_reg, src_h_reg;
	logic [10:0] dst_w_reg, dst_h_reg;
	logic [23:0] x_inc_reg, y_inc_reg;
	logic [23:0] shadow_store [STORE_DEPTH];
	logic [15:0] load_ptr;
	logic [23:0] x_pos, y_pos;
	int unsigned dst_col, dst_row;

	dest_pixel_t pending_pixels[$];
	int errors = 0;
	int pixels_seen = 0;
	int frames_done = 0;
	int loads_sent = 0;
	int stall_out = 1;  // 0 disables output backpressure for a stretch

	always #4 clk = ~clk;

	triangle_bilinear_image_resizer u_top (.*);

	function automatic int unsigned fit_size(int unsigned v, int unsigned max);
		if (v == 0) return 1;
		return v > max ? max : v;
	endfunction

	function automatic logic [23:0] read_source(int unsigned col, int unsigned row,
			int unsigned sw, int unsigned sh);
		int unsigned c, r;
		c = col >= sw ? sw - 1 : col;
		r = row >= sh ? sh - 1 : row;
		return shadow_store[r * sw + c];
	endfunction

	// v00 + floor((dx*xf + dy*yf) / 2^16), arithmetic shift gives the floor
	function automatic logic [7:0] tri_blend(logic [7:0] a, logic [7:0] b, logic [7:0] c,
			longint xf, longint yf);
		longint s;
		s = (longint'(b) - longint'(a)) * xf + (longint'(c) - longint'(a)) * yf;
		return 8'(longint'(a) + (s >>> 16));
	endfunction

	function automatic dest_pixel_t predict_pixel();
		dest_pixel_t px;
		int unsigned sw, sh, dw, dh, xi, yi;
		longint xf, yf;
		logic [23:0] pa, pb, pc;
		sw = fit_size(src_w_reg, 256);
		sh = fit_size(src_h_reg, 256);
		dw = fit_size(dst_w_reg, 1024);
		dh = fit_size(dst_h_reg, 1024);
		xi = x_pos[23:16];
		yi = y_pos[23:16];
		xf = x_pos[15:0];
		yf = y_pos[15:0];
		if (xf + yf <= 65536) begin
			pa = read_source(xi, yi, sw, sh);
			pb = read_source(xi + 1, yi, sw, sh);
			pc = read_source(xi, yi + 1, sw, sh);
		end else begin
			// mirrored triangle anchored at the bottom-right corner
			xf = 65536 - xf;
			yf = 65536 - yf;
			pa = read_source(xi + 1, yi + 1, sw, sh);
			pb = read_source(xi, yi + 1, sw, sh);
			pc = read_source(xi + 1, yi, sw, sh);
		end
		px.red = tri_blend(pa[23:16], pb[23:16], pc[23:16], xf, yf);
		px.green = tri_blend(pa[15:8], pb[15:8], pc[15:8], xf, yf);
		px.blue = tri_blend(pa[7:0], pb[7:0], pc[7:0], xf, yf);
		px.last_pixel = (dst_col + 1 >= dw) && (dst_row + 1 >= dh);
		if (px.last_pixel) begin
			x_pos = '0; y_pos = '0; dst_col = 0; dst_row = 0; load_ptr = '0;
		end else if (dst_col + 1 >= dw) begin
			dst_col = 0;
			x_pos = '0;
			dst_row++;
			y_pos = y_pos + y_inc_reg;
		end else begin
			dst_col++;
			x_pos = x_pos + x_inc_reg;
		end
		return px;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int n;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 2) == 0) n = 0;
		return n;
	endfunction

	// rgb holds red high, blue low; the bus carries red in the low byte
	task automatic send_beat(logic action, logic [23:0] rgb);
		int n;
		n = gap_len();
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= action;
		s_axis_tdata <= {rgb[7:0], rgb[15:8], rgb[23:16]};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		// beat accepted at this edge: update the shadow
		if (action == ACT_LOAD) begin
			shadow_store[load_ptr] = rgb;
			load_ptr = load_ptr + 1'b1;
			loads_sent++;
		end else begin
			pending_pixels.push_back(predict_pixel());
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SRC_W: src_w_reg = val[8:0];
			REG_SRC_H: src_h_reg = val[8:0];
			REG_DST_W: dst_w_reg = val[10:0];
			REG_DST_H: dst_h_reg = val[10:0];
			REG_X_INC: x_inc_reg = val;
			REG_Y_INC: y_inc_reg = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic setup_geometry(int sw, int sh, int dw, int dh, int xi, int yi);
		drain();
		write_reg(REG_SRC_W, CFG_DATA_W'(sw));
		write_reg(REG_SRC_H, CFG_DATA_W'(sh));
		write_reg(REG_DST_W, CFG_DATA_W'(dw));
		write_reg(REG_DST_H, CFG_DATA_W'(dh));
		write_reg(REG_X_INC, CFG_DATA_W'(xi));
		write_reg(REG_Y_INC, CFG_DATA_W'(yi));
	endtask

	// load a whole source image, then emit a whole destination frame;
	// a frame always restarts the store at entry 0, so every read is of loaded data
	task automatic run_frame(bit extremes);
		int sw, sh;
		sw = fit_size(src_w_reg, 256);
		sh = fit_size(src_h_reg, 256);
		for (int i = 0; i < sw * sh; i++)
			send_beat(ACT_LOAD, extremes ? (i[0] ? 24'hffffff : 24'h000000) : 24'($urandom));
		for (int i = 0; i < fit_size(dst_w_reg, 1024) * fit_size(dst_h_reg, 1024); i++)
			send_beat(ACT_EMIT, 24'($urandom));
		frames_done++;
	endtask

	task automatic test_directed();
		// identity on a tiny image, alternating black and white pixels
		setup_geometry(2, 2, 2, 2, 24'h010000, 24'h010000);
		run_frame(1);
		// upscale with fractions in both triangles and edge clamping
		setup_geometry(3, 2, 5, 3, 24'h008000, 24'h00c000);
		run_frame(1);
		// single pixel image and zero increment
		setup_geometry(1, 1, 1, 1, 0, 0);
		run_frame(0);
		// zero sizes act as one, maximal increment clamps
		setup_geometry(0, 0, 2, 2, 24'hffffff, 24'hffffff);
		run_frame(1);
		// wait until every result has come out
		drain();
	endtask

	task automatic test_random_frames();
		int sw, sh, dw, dh;
		while (loads_sent + pixels_seen + pending_pixels.size() < 400) begin
			sw = $urandom_range(1, 6);
			sh = $urandom_range(1, 6);
			dw = $urandom_range(1, 9);
			dh = $urandom_range(1, 8);
			setup_geometry(sw, sh, dw, dh,
				(dw > 1) ? ((sw - 1) << 16) / (dw - 1) + $urandom_range(0, 3) : $urandom,
				(dh > 1) ? ((sh - 1) << 16) / (dh - 1) : $urandom_range(0, 24'hffffff));
			stall_out = $urandom_range(0, 3) != 0;
			run_frame(0);
		end
		stall_out = 1;
	endtask

	task automatic test_wide_frame();
		// oversized source width falls back to the full 256-pixel row
		setup_geometry(9'h1ff, 1, 8, 1, (255 << 16) / 7, 0);
		run_frame(0);
	endtask

	// output side: random backpressure, compare against the oldest prediction
	initial begin
		dest_pixel_t exp_px;
		@(posedge arst_n);
		forever begin
			m_axis_tready <= stall_out ? ($urandom_range(0, 3) != 0) : 1'b1;
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				pixels_seen++;
				if (pending_pixels.size() == 0) begin
					$error("unexpected pixel %h", m_axis_tdata);
					errors++;
				end else begin
					exp_px = pending_pixels.pop_front();
					if (m_axis_tdata[7:0] != exp_px.red) begin
						$error("out_red exp %h got %h", exp_px.red, m_axis_tdata[7:0]);
						errors++;
					end
					if (m_axis_tdata[15:8] != exp_px.green) begin
						$error("out_green exp %h got %h", exp_px.green, m_axis_tdata[15:8]);
						errors++;
					end
					if (m_axis_tdata[23:16] != exp_px.blue) begin
						$error("out_blue exp %h got %h", exp_px.blue, m_axis_tdata[23:16]);
						errors++;
					end
					if (m_axis_tlast != exp_px.last_pixel) begin
						$error("last_pixel exp %b got %b", exp_px.last_pixel, m_axis_tlast);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		src_w_reg = 256; src_h_reg = 256; dst_w_reg = 256; dst_h_reg = 256;
		x_inc_reg = 24'h010000; y_inc_reg = 24'h010000;
		load_ptr = '0; x_pos = '0; y_pos = '0; dst_col = 0; dst_row = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_frames();
		test_wide_frame();
		drain();
		$display("covered %0d frames, %0d loads, %0d destination pixels checked",
			frames_done, loads_sent, pixels_seen);
		if (errors == 0 && pending_pixels.size() == 0)
			$display("triangle_bilinear_image_resizer regression: pass");
		else
			$display("triangle_bilinear_image_resizer regression: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("triangle_bilinear_image_resizer regression: fail");
		$finish;
	end
endmodule
